// File: hdl/csgd_pkg.sv
// ============================================================================
// csgd_pkg
// Shared types, sizes, codes and arithmetic helpers for the clipped SGD
// weight update block.
// ============================================================================
package csgd_pkg;

    // Layer size
    localparam int IN_NODES     = 64;
    localparam int OUT_NODES    = 64;
    localparam int WEIGHT_COUNT = IN_NODES * OUT_NODES;
    localparam int PARAM_COUNT  = WEIGHT_COUNT + OUT_NODES;

    // Address widths (at least one bit each)
    localparam int W_AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
    localparam int B_AW = (OUT_NODES > 1) ? $clog2(OUT_NODES) : 1;
    localparam int I_AW = (IN_NODES > 1) ? $clog2(IN_NODES) : 1;

    // Field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 13;
    localparam int DATA_W = 32;
    localparam int LR_W   = 21;
    localparam int CLIP_W = 31;
    localparam int M1_W   = LR_W + DATA_W;   // rate times delta magnitude

    // Register reset values
    localparam logic [LR_W-1:0]   LR_RESET   = LR_W'(6554);
    localparam logic [CLIP_W-1:0] CLIP_RESET = CLIP_W'(327680);

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_LATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_APPLY = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // Store targeted by a command
    localparam logic [1:0] TGT_NONE   = 2'd0;
    localparam logic [1:0] TGT_WEIGHT = 2'd1;
    localparam logic [1:0] TGT_BIAS   = 2'd2;
    localparam logic [1:0] TGT_INPUT  = 2'd3;

    // Command queue depth
    localparam int QDEPTH = 2;
    localparam int Q_PW   = 1;
    localparam int Q_CW   = 2;

    // Classified command passed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [1:0]        tgt;
        logic [W_AW-1:0]   addr;
        logic [DATA_W-1:0] value;
    } csgd_cmd_t;

    // w - g (neg = 0) or w + g (neg = 1), saturated to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] w,
                                                  input logic [CLIP_W-1:0] g,
                                                  input logic neg);
        logic signed [DATA_W+1:0] wx;
        logic signed [DATA_W+1:0] gx;
        logic signed [DATA_W+1:0] r;
        logic [DATA_W-1:0]        res;
        wx = $signed({{2{w[DATA_W-1]}}, w});
        gx = $signed({3'b000, g});
        r  = neg ? (wx + gx) : (wx - gx);
        if (r[DATA_W+1:DATA_W-1] == 3'b000 || r[DATA_W+1:DATA_W-1] == 3'b111)
            res = r[DATA_W-1:0];
        else if (r[DATA_W+1])
            res = {1'b1, {(DATA_W-1){1'b0}}};
        else
            res = {1'b0, {(DATA_W-1){1'b1}}};
        return res;
    endfunction

endpackage

// File: hdl/csgd_ram.sv
// ============================================================================
// csgd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module csgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/csgd_front.sv
// ============================================================================
// csgd_front
// Accepts commands, classifies index ranges into a target store and local
// address, and holds them in a short queue for the back end.
// ============================================================================
module csgd_front
    import csgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [IDX_W-1:0]  index,
    input  logic [DATA_W-1:0] value,
    output logic              q_valid,
    output csgd_cmd_t         q_cmd,
    input  logic              q_pop
);

    csgd_cmd_t        cmd_in;
    csgd_cmd_t        q_reg [QDEPTH];
    logic [Q_PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]  count_reg, count_next;
    logic             push;
    logic [31:0]      idx32;

    assign idx32 = 32'(index);

    // Range classification
    always_comb
    begin
        cmd_in.op    = op;
        cmd_in.value = value;
        cmd_in.tgt   = TGT_NONE;
        cmd_in.addr  = '0;
        case (op)
            OP_WRITE, OP_READ:
            begin
                if (idx32 < 32'(WEIGHT_COUNT))
                begin
                    cmd_in.tgt  = TGT_WEIGHT;
                    cmd_in.addr = W_AW'(idx32);
                end
                else if (idx32 < 32'(PARAM_COUNT))
                begin
                    cmd_in.tgt  = TGT_BIAS;
                    cmd_in.addr = W_AW'(idx32 - 32'(WEIGHT_COUNT));
                end
            end
            OP_LATCH:
            begin
                if (idx32 < 32'(IN_NODES))
                begin
                    cmd_in.tgt  = TGT_INPUT;
                    cmd_in.addr = W_AW'(idx32);
                end
            end
            OP_APPLY:
            begin
                // column of the delta; bias tag marks it in range
                if (idx32 < 32'(OUT_NODES))
                begin
                    cmd_in.tgt  = TGT_BIAS;
                    cmd_in.addr = W_AW'(idx32);
                end
            end
            default:
            begin
                cmd_in.tgt = TGT_NONE;
            end
        endcase
    end

    // Queue control
    assign busy    = (count_reg == Q_CW'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

// File: hdl/csgd_back.sv
// ============================================================================
// csgd_back
// Executes queued commands against the weight, bias and input stores.
// Applying a delta walks the column through a three-stage read-modify-write
// pipeline, then updates the bias.
// ============================================================================
module csgd_back
    import csgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  csgd_cmd_t         q_cmd,
    output logic              q_pop,
    input  logic [LR_W-1:0]   step_rate,
    input  logic [CLIP_W-1:0] clip_limit,
    output logic              done,
    output logic [DATA_W-1:0] read_value,
    output logic [OP_W-1:0]   done_op
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_READ     = 3'd2;
    localparam logic [2:0] ST_WALK     = 3'd3;
    localparam logic [2:0] ST_DRAIN    = 3'd4;

    logic [2:0]        state_reg, state_next;
    csgd_cmd_t         cur_reg, cur_next;
    logic [M1_W-1:0]   m1_reg, m1_next;
    logic [I_AW-1:0]   row_reg, row_next;
    logic [W_AW-1:0]   iss_addr_reg, iss_addr_next;

    // Pipeline stages
    logic              s1_v_reg, s1_v_next;
    logic [W_AW-1:0]   s1_addr_reg;
    logic              s2_v_reg;
    logic [LR_W+DATA_W-1:0] s2_hi_reg;
    logic [DATA_W-1:0] s2_lo_reg;
    logic [DATA_W-1:0] s2_w_reg;
    logic              s2_neg_reg;
    logic [W_AW-1:0]   s2_addr_reg;
    logic              s3_v_reg;
    logic [CLIP_W-1:0] s3_g_reg;
    logic [DATA_W-1:0] s3_w_reg;
    logic              s3_neg_reg;
    logic [W_AW-1:0]   s3_addr_reg;

    // Result registers
    logic              done_reg, done_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;
    logic [OP_W-1:0]   done_op_reg, done_op_next;

    // Memory ports
    logic              w_we, b_we, i_we;
    logic [W_AW-1:0]   w_waddr, w_raddr;
    logic [DATA_W-1:0] w_wdata, w_rdata, b_wdata, b_rdata, i_rdata;
    logic [B_AW-1:0]   b_addr;
    logic [I_AW-1:0]   i_waddr;

    // Arithmetic
    logic [DATA_W-1:0]        dmag;
    logic [DATA_W-1:0]        xmag;
    logic [2*DATA_W-1:0]      lo_prod;
    logic [M1_W:0]            g_sum;
    logic [CLIP_W-1:0]        g_clip;
    logic [M1_W-17:0]         bg;
    logic [CLIP_W-1:0]        bg_clip;
    logic                     pipe_empty;

    csgd_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_COUNT)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    csgd_ram #(.WIDTH(DATA_W), .DEPTH(OUT_NODES)) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_addr),
        .wdata (b_wdata),
        .raddr (b_addr),
        .rdata (b_rdata)
    );

    csgd_ram #(.WIDTH(DATA_W), .DEPTH(IN_NODES)) u_input_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (cur_reg.value),
        .raddr (row_reg),
        .rdata (i_rdata)
    );

    // Stage 1: activation magnitude and the two partial products
    assign dmag    = cur_reg.value[DATA_W-1] ? (~cur_reg.value + 1'b1) : cur_reg.value;
    assign xmag    = i_rdata[DATA_W-1] ? (~i_rdata + 1'b1) : i_rdata;
    assign lo_prod = m1_reg[DATA_W-1:0] * xmag;

    // Stage 2: sum and clip
    assign g_sum  = (M1_W+1)'(s2_hi_reg) + (M1_W+1)'(s2_lo_reg);
    assign g_clip = (g_sum > (M1_W+1)'(clip_limit)) ? clip_limit : CLIP_W'(g_sum);

    // Bias gradient: rate times delta, Q16.16
    assign bg      = m1_reg[M1_W-1:16];
    assign bg_clip = (bg > (M1_W-16)'(clip_limit)) ? clip_limit : CLIP_W'(bg);

    assign pipe_empty = !s1_v_reg && !s2_v_reg && !s3_v_reg;

    // Memory control
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = cur_reg.addr;
        w_wdata = cur_reg.value;
        b_we    = 1'b0;
        b_wdata = cur_reg.value;
        i_we    = 1'b0;
        i_waddr = cur_reg.addr[I_AW-1:0];
        b_addr  = cur_reg.addr[B_AW-1:0];
        w_raddr = (state_reg == ST_WALK) ? iss_addr_reg : cur_reg.addr;

        if (s3_v_reg)
        begin
            w_we    = 1'b1;
            w_waddr = s3_addr_reg;
            w_wdata = sub_sat(s3_w_reg, s3_g_reg, s3_neg_reg);
        end
        else if (state_reg == ST_DISPATCH && cur_reg.op == OP_WRITE
                 && cur_reg.tgt == TGT_WEIGHT)
        begin
            w_we = 1'b1;
        end

        if (state_reg == ST_DISPATCH && cur_reg.op == OP_WRITE && cur_reg.tgt == TGT_BIAS)
            b_we = 1'b1;
        if (state_reg == ST_DRAIN && pipe_empty)
        begin
            b_we    = 1'b1;
            b_wdata = sub_sat(b_rdata, bg_clip, cur_reg.value[DATA_W-1]);
        end

        if (state_reg == ST_DISPATCH && cur_reg.op == OP_LATCH && cur_reg.tgt == TGT_INPUT)
            i_we = 1'b1;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        m1_next         = m1_reg;
        row_next        = row_reg;
        iss_addr_next   = iss_addr_reg;
        s1_v_next       = 1'b0;
        q_pop           = 1'b0;
        done_next       = 1'b0;
        read_value_next = read_value_reg;
        done_op_next    = done_op_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_cmd;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                read_value_next = '0;
                done_op_next    = cur_reg.op;
                if (cur_reg.op == OP_READ && cur_reg.tgt != TGT_NONE)
                begin
                    state_next = ST_READ;
                end
                else if (cur_reg.op == OP_APPLY && cur_reg.tgt != TGT_NONE)
                begin
                    m1_next       = M1_W'(step_rate) * M1_W'(dmag);
                    row_next      = '0;
                    iss_addr_next = cur_reg.addr;
                    state_next    = ST_WALK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                read_value_next = (cur_reg.tgt == TGT_WEIGHT) ? w_rdata : b_rdata;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_WALK:
            begin
                // one row issued per cycle
                s1_v_next     = 1'b1;
                row_next      = row_reg + 1'b1;
                iss_addr_next = iss_addr_reg + W_AW'(OUT_NODES);
                if (row_reg == I_AW'(IN_NODES - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        m1_reg         <= m1_next;
        row_reg        <= row_next;
        iss_addr_reg   <= iss_addr_next;
        read_value_reg <= read_value_next;
        done_op_reg    <= done_op_next;
        s1_addr_reg    <= iss_addr_reg;
        s2_hi_reg      <= m1_reg[M1_W-1:DATA_W] * xmag;
        s2_lo_reg      <= lo_prod[2*DATA_W-1:DATA_W];
        s2_w_reg       <= w_rdata;
        s2_neg_reg     <= cur_reg.value[DATA_W-1] ^ i_rdata[DATA_W-1];
        s2_addr_reg    <= s1_addr_reg;
        s3_g_reg       <= g_clip;
        s3_w_reg       <= s2_w_reg;
        s3_neg_reg     <= s2_neg_reg;
        s3_addr_reg    <= s2_addr_reg;
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign done_op    = done_op_reg;

endmodule

// File: hdl/clipped_sgd_weight_update.sv
// ============================================================================
// clipped_sgd_weight_update
// Dense-layer parameter store with clipped SGD update in Q16.16.
// ============================================================================
// Usage:
//   Commands (op, index, value) transfer at a rising edge with start high and
//   busy low. A two-entry queue sits between the decode front end and the
//   execution back end, so busy rises only when both entries are taken.
//   Each command produces exactly one result: done pulses for one cycle with
//   read_value (nonzero only for a parameter read) and done_op. The receiver
//   cannot stall; results are never held.
//   An apply-delta reads one column row, updates it through a three-stage
//   multiply/clip/saturate pipeline and writes it back per cycle, followed
//   by the bias update. Commands execute one at a time: the back end takes
//   a new one only after the previous one has finished.
//   The step rate (0x0) and clip limit (0x4) are written over the APB port;
//   the user must write them only while the block is idle, as the block
//   itself does not enforce it.
//   Reset restores the register defaults and empties the queue; the stores
//   keep no reset value and must be written before use.
// ============================================================================
module clipped_sgd_weight_update
    import csgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [IDX_W-1:0]  index,
    input  logic [DATA_W-1:0] value,
    output logic              done,
    output logic [DATA_W-1:0] read_value,
    output logic [OP_W-1:0]   done_op,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [LR_W-1:0]   lr_reg;
    logic [CLIP_W-1:0] clip_reg;
    logic              cfg_we;
    logic              q_valid;
    logic              q_pop;
    csgd_cmd_t         q_cmd;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(clip_reg) : 32'(lr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LR_RESET;
            clip_reg <= CLIP_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2])
                clip_reg <= pwdata[CLIP_W-1:0];
            else
                lr_reg <= pwdata[LR_W-1:0];
        end
    end

    csgd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .op      (op),
        .index   (index),
        .value   (value),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    csgd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .step_rate  (lr_reg),
        .clip_limit (clip_reg),
        .done       (done),
        .read_value (read_value),
        .done_op    (done_op)
    );

    // Result strobes never come back to back
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // The queue fills only on a command transfer
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transfer");

    // Only a read returns data
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_value != '0) |-> (done_op == OP_READ))
        else $error("nonzero read_value on a non-read result");

endmodule
